>>> hdl/wks_pkg.sv
// Package for the weighted keyword scanner: keyword table, weights, categories,
// the result accumulator type and ASCII constants. No dependencies.
package wks_pkg;

  localparam int TABLE_SIZE = 19;
  localparam int KEY_MAX    = 31;
  localparam int SCORE_W    = 7;

  localparam logic [SCORE_W-1:0] SCORE_CAP = 7'd100;

  localparam logic [7:0] NUL_BYTE      = 8'h00;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET   = 8'h20;

  typedef enum logic [2:0] {
    CAT_NONE       = 3'd0,
    CAT_BANKING    = 3'd1,
    CAT_LOTTERY    = 3'd2,
    CAT_GOVERNMENT = 3'd3,
    CAT_DELIVERY   = 3'd4,
    CAT_URGENCY    = 3'd5
  } cat_e;

  // Running result handed from one summing cell to the next.
  typedef struct packed {
    logic               any;
    logic [SCORE_W-1:0] sum;
    logic [SCORE_W-1:0] top_w;
    cat_e               cat;
  } acc_t;

  // Keywords, right-justified: the last character sits in bits [7:0].
  localparam logic [8*KEY_MAX-1:0] KEY_STR [TABLE_SIZE] = '{
    "your account has been suspended",
    "otp",
    "kyc verification",
    "upi pin",
    "net banking",
    "debit card",
    "congratulations you have won",
    "lucky draw",
    "prize money",
    "claim your reward",
    "income tax department",
    "aadhaar blocked",
    "police complaint",
    "court summons",
    "your parcel is held",
    "customs duty",
    "immediate action required",
    "click here to avoid",
    "limited time offer"
  };

  localparam int KEY_LEN [TABLE_SIZE] = '{
    31, 3, 16, 7, 11, 10, 28, 10, 11, 17, 21, 15, 16, 13, 19, 12, 25, 19, 18
  };

  localparam logic [SCORE_W-1:0] KEY_WEIGHT [TABLE_SIZE] = '{
    7'd90, 7'd30, 7'd80, 7'd85, 7'd40, 7'd35, 7'd95, 7'd85, 7'd80, 7'd75,
    7'd85, 7'd90, 7'd70, 7'd80, 7'd80, 7'd70, 7'd60, 7'd65, 7'd40
  };

  localparam cat_e KEY_CAT [TABLE_SIZE] = '{
    CAT_BANKING, CAT_BANKING, CAT_BANKING, CAT_BANKING, CAT_BANKING, CAT_BANKING,
    CAT_LOTTERY, CAT_LOTTERY, CAT_LOTTERY, CAT_LOTTERY,
    CAT_GOVERNMENT, CAT_GOVERNMENT, CAT_GOVERNMENT, CAT_GOVERNMENT,
    CAT_DELIVERY, CAT_DELIVERY,
    CAT_URGENCY, CAT_URGENCY, CAT_URGENCY
  };

  // Rules past the table have no keyword and zero weight.
  function automatic int rule_len(input int idx);
    int len;
    len = 0;
    if (idx < TABLE_SIZE) begin
      len = KEY_LEN[idx];
    end
    return len;
  endfunction

  function automatic logic [SCORE_W-1:0] rule_weight(input int idx);
    logic [SCORE_W-1:0] w;
    w = '0;
    if (idx < TABLE_SIZE) begin
      w = KEY_WEIGHT[idx];
    end
    return w;
  endfunction

  function automatic cat_e rule_cat(input int idx);
    cat_e c;
    c = CAT_NONE;
    if (idx < TABLE_SIZE) begin
      c = KEY_CAT[idx];
    end
    return c;
  endfunction

  // Character pos (0 = first) of keyword idx.
  function automatic logic [7:0] key_byte(input int idx, input int pos);
    logic [7:0] b;
    b = NUL_BYTE;
    if (idx < TABLE_SIZE) begin
      b = KEY_STR[idx][8*(KEY_LEN[idx]-1-pos) +: 8];
    end
    return b;
  endfunction

endpackage

>>> hdl/wks_win_cell.sv
// One byte cell of the scan window; takes its neighbor's byte on each shift.
// Depends on nothing but the clock and reset.
module wks_win_cell (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic       clear_i,
  input  logic [7:0] byte_i,
  input  logic       vld_i,
  output logic [7:0] byte_o,
  output logic       vld_o
);

  logic [7:0] byte_q;
  logic       vld_q, vld_d;

  always_comb begin
    vld_d = vld_q;
    if (clear_i) begin
      vld_d = 1'b0;
    end else if (shift_i) begin
      vld_d = vld_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;
  assign vld_o  = vld_q;

endmodule

>>> hdl/wks_sum_cell.sv
// One summing cell: folds the weight and category of rule IDX into the running
// result, then hands it on. Depends on wks_pkg.
module wks_sum_cell import wks_pkg::*; #(
  parameter int RULE_COUNT = 19,
  parameter int IDX        = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  output logic                  rdy_o,
  input  logic [RULE_COUNT-1:0] hit_i,
  input  acc_t                  acc_i,
  output logic                  vld_o,
  input  logic                  rdy_i,
  output logic [RULE_COUNT-1:0] hit_o,
  output acc_t                  acc_o
);

  localparam logic [SCORE_W-1:0] Weight = rule_weight(IDX);
  localparam cat_e               Cat    = rule_cat(IDX);

  logic                  vld_q;
  logic [RULE_COUNT-1:0] hit_q;
  acc_t                  acc_q, acc_d;
  logic [SCORE_W:0]      sum_wide;

  assign rdy_o = !vld_q || rdy_i;

  always_comb begin
    acc_d    = acc_i;
    sum_wide = {1'b0, acc_i.sum} + {1'b0, Weight};
    if (hit_i[IDX]) begin
      if (sum_wide > {1'b0, SCORE_CAP}) begin
        acc_d.sum = SCORE_CAP;
      end else begin
        acc_d.sum = sum_wide[SCORE_W-1:0];
      end
      // strictly heavier only: the earlier rule keeps ties
      if (Weight > acc_i.top_w) begin
        acc_d.top_w = Weight;
        acc_d.cat   = Cat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) begin
      hit_q <= hit_i;
      acc_q <= acc_d;
    end
  end

  assign vld_o = vld_q;
  assign hit_o = hit_q;
  assign acc_o = acc_q;

endmodule

>>> hdl/weighted_keyword_scanner.sv
// Weighted keyword scanner top level: byte window cells, keyword comparators,
// hit register and the chain of summing cells. Depends on wks_pkg,
// wks_win_cell and wks_sum_cell.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------
//  in      | into      | in_valid_i/in_stall_o | text_byte_i, byte_present_i,
//          |           |                       | last_byte_i
//  out     | out of    | out_valid_o/          | score_o, any_match_o, category_o
//          |           | out_stall_i           |
//
// One input item per cycle while in_stall_o is low. Bytes that do not end a message are never stalled.
// A message's result passes down the summing chain (one cell per rule) once its last
// item is taken; results of up to RULE_COUNT messages can be in flight at once.
// in_stall_o rises only for a last item while the first summing cell is full
// and cannot move on, i.e. when out_stall_i has backed the whole chain up.
// Reset clears the window, hit bits and all chain valids at once.
module weighted_keyword_scanner import wks_pkg::*; #(
  parameter int WINDOW_LEN = 32,
  parameter int RULE_COUNT = 19
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [7:0]   text_byte_i,
  input  logic         byte_present_i,
  input  logic         last_byte_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [6:0]   score_o,
  output logic         any_match_o,
  output logic [2:0]   category_o
);

  // ---------------------------------------------------------------------------
  // Front end: transfer qualification and case folding
  // ---------------------------------------------------------------------------
  logic       accept;
  logic       scan;    // byte enters the window this cycle
  logic       clear;   // last item of the message: flush all message state
  logic [7:0] folded;

  logic                  ended_q, ended_d;
  logic [RULE_COUNT-1:0] hit_q, hit_d;
  logic [RULE_COUNT-1:0] match;
  logic [RULE_COUNT-1:0] hit_now;  // hits including the current byte

  // chain of summing cells; index 0 is the chain input
  logic                  sum_vld [RULE_COUNT+1];
  logic                  sum_rdy [RULE_COUNT+1];
  logic [RULE_COUNT-1:0] sum_hit [RULE_COUNT];
  acc_t                  sum_acc [RULE_COUNT+1];

  assign accept = in_valid_i && !in_stall_o;
  assign scan   = accept && byte_present_i && !ended_q && (text_byte_i != NUL_BYTE);
  assign clear  = accept && last_byte_i;

  assign folded = ((text_byte_i >= ASCII_UPPER_A) && (text_byte_i <= ASCII_UPPER_Z))
                  ? text_byte_i + CASE_OFFSET : text_byte_i;

  // ---------------------------------------------------------------------------
  // Window: a shift line of byte cells. tap[p] is the byte in window slot p
  // once the current byte has shifted in; tap[WINDOW_LEN] is the new byte.
  // Slot 0 of the window is only ever seen after a shift, so it needs no cell.
  // A cell without a valid byte never matches (stands for the zero fill).
  // ---------------------------------------------------------------------------
  logic [7:0]          tap_byte [1:WINDOW_LEN];
  logic [WINDOW_LEN:1] tap_vld;

  assign tap_byte[WINDOW_LEN] = folded;
  assign tap_vld[WINDOW_LEN]  = 1'b1;

  for (genvar k = 1; k < WINDOW_LEN; k++) begin : g_win
    wks_win_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (scan),
      .clear_i (clear),
      .byte_i  (tap_byte[k+1]),
      .vld_i   (tap_vld[k+1]),
      .byte_o  (tap_byte[k]),
      .vld_o   (tap_vld[k])
    );
  end

  // ---------------------------------------------------------------------------
  // Keyword comparators: each rule looks at the tail of the shifted window.
  // Rules past the table, or longer than the window, never match.
  // ---------------------------------------------------------------------------
  for (genvar r = 0; r < RULE_COUNT; r++) begin : g_rule
    localparam int Len = rule_len(r);
    if ((Len > 0) && (Len <= WINDOW_LEN)) begin : g_cmp
      logic [Len-1:0] eq;
      for (genvar j = 0; j < Len; j++) begin : g_chr
        localparam int Slot = WINDOW_LEN - Len + j + 1;
        assign eq[j] = tap_vld[Slot] && (tap_byte[Slot] == key_byte(r, j));
      end
      assign match[r] = &eq;
    end else begin : g_none
      assign match[r] = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-message state: sticky hit bits and the end-of-text flag
  // ---------------------------------------------------------------------------
  assign hit_now = scan ? (hit_q | match) : hit_q;

  always_comb begin
    hit_d   = hit_now;
    ended_d = ended_q;
    if (clear) begin
      hit_d   = '0;
      ended_d = 1'b0;
    end else if (accept && byte_present_i && (text_byte_i == NUL_BYTE)) begin
      ended_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q   <= '0;
      ended_q <= 1'b0;
    end else begin
      hit_q   <= hit_d;
      ended_q <= ended_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Summing chain: one cell per rule, each adds its weight if its hit bit is
  // set. Only a last item needs a free slot at the chain input.
  // ---------------------------------------------------------------------------
  assign in_stall_o = last_byte_i && !sum_rdy[0];

  assign sum_vld[0] = clear;
  assign sum_hit[0] = hit_now;
  // any = |hit_now, sum and top weight zero, no category yet
  assign sum_acc[0] = {|hit_now, {SCORE_W{1'b0}}, {SCORE_W{1'b0}}, CAT_NONE};

  for (genvar r = 0; r < RULE_COUNT; r++) begin : g_sum
    if (r < RULE_COUNT - 1) begin : g_mid
      wks_sum_cell #(
        .RULE_COUNT (RULE_COUNT),
        .IDX        (r)
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .vld_i  (sum_vld[r]),
        .rdy_o  (sum_rdy[r]),
        .hit_i  (sum_hit[r]),
        .acc_i  (sum_acc[r]),
        .vld_o  (sum_vld[r+1]),
        .rdy_i  (sum_rdy[r+1]),
        .hit_o  (sum_hit[r+1]),
        .acc_o  (sum_acc[r+1])
      );
    end else begin : g_end
      wks_sum_cell #(
        .RULE_COUNT (RULE_COUNT),
        .IDX        (r)
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .vld_i  (sum_vld[r]),
        .rdy_o  (sum_rdy[r]),
        .hit_i  (sum_hit[r]),
        .acc_i  (sum_acc[r]),
        .vld_o  (sum_vld[r+1]),
        .rdy_i  (sum_rdy[r+1]),
        .hit_o  (),
        .acc_o  (sum_acc[r+1])
      );
    end
  end

  // last cell doubles as the output register
  assign sum_rdy[RULE_COUNT] = !out_stall_i;
  assign out_valid_o = sum_vld[RULE_COUNT];
  assign score_o     = sum_acc[RULE_COUNT].sum;
  assign any_match_o = sum_acc[RULE_COUNT].any;
  assign category_o  = sum_acc[RULE_COUNT].cat;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_score_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (score_o <= SCORE_CAP))
    else $error("score above cap");

  a_no_match_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !any_match_o) |-> ((score_o == '0) && (category_o == CAT_NONE)))
    else $error("result without a match carries score or category");

  a_match_has_cat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && any_match_o) |-> ((category_o != CAT_NONE) && (score_o != '0)))
    else $error("matched result without category or score");

  a_flush : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear |=> ((hit_q == '0) && !ended_q))
    else $error("message state not flushed after last item");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Testbench for weighted_keyword_scanner: directed and random messages against
// a scan predictor kept here. Depends on wks_pkg (types, ASCII constants) and the RTL.
module tb;
  import wks_pkg::*;

  localparam int WINDOW = 32;
  localparam int RULES  = 19;

  // Expected result of one message.
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               any_match;
    cat_e               category;
  } verdict_t;

  logic         clk_i;
  logic         rst_ni         = 1'b0;
  logic         in_valid_i     = 1'b0;
  logic         in_stall_o;
  logic [7:0]   text_byte_i    = 8'h00;
  logic         byte_present_i = 1'b0;
  logic         last_byte_i    = 1'b0;
  logic         out_valid_o;
  logic         out_stall_i    = 1'b0;
  logic [6:0]   score_o;
  logic         any_match_o;
  logic [2:0]   category_o;

  weighted_keyword_scanner #(
    .WINDOW_LEN(WINDOW),
    .RULE_COUNT(RULES)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .text_byte_i   (text_byte_i),
    .byte_present_i(byte_present_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .score_o       (score_o),
    .any_match_o   (any_match_o),
    .category_o    (category_o)
  );

  // Keyword table, kept independent of the package copy so a bad table in the
  // RTL shows up as a mismatch.
  string kw_text [RULES] = '{
    "your account has been suspended", "otp", "kyc verification", "upi pin",
    "net banking", "debit card", "congratulations you have won", "lucky draw",
    "prize money", "claim your reward", "income tax department",
    "aadhaar blocked", "police complaint", "court summons",
    "your parcel is held", "customs duty", "immediate action required",
    "click here to avoid", "limited time offer"
  };
  int unsigned kw_weight [RULES] = '{
    90, 30, 80, 85, 40, 35, 95, 85, 80, 75, 85, 90, 70, 80, 80, 70, 60, 65, 40
  };
  cat_e kw_cat [RULES] = '{
    CAT_BANKING, CAT_BANKING, CAT_BANKING, CAT_BANKING, CAT_BANKING, CAT_BANKING,
    CAT_LOTTERY, CAT_LOTTERY, CAT_LOTTERY, CAT_LOTTERY,
    CAT_GOVERNMENT, CAT_GOVERNMENT, CAT_GOVERNMENT, CAT_GOVERNMENT,
    CAT_DELIVERY, CAT_DELIVERY,
    CAT_URGENCY, CAT_URGENCY, CAT_URGENCY
  };

  // Predictor state: byte window (oldest at index 0), fill count, hit bits
  // and the end-of-text flag set by a zero byte.
  logic [7:0]       win_bytes [WINDOW];
  int               win_fill;
  logic [RULES-1:0] hit_mask;
  bit               text_done;

  verdict_t pending_verdicts [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int result_count   = 0;
  int scan_items     = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void report_failure(string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("ERROR: %s", msg);
    end
  endfunction

  function automatic void clear_scan_state();
    foreach (win_bytes[i]) begin
      win_bytes[i] = 8'h00;
    end
    win_fill  = 0;
    hit_mask  = '0;
    text_done = 1'b0;
  endfunction

  // Fold, shift into the window, then test every keyword against the tail.
  function automatic void shift_in_byte(logic [7:0] b);
    logic [7:0] folded;
    int         len;
    bit         same;
    folded = (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) ? b + CASE_OFFSET : b;
    for (int i = 0; i < WINDOW - 1; i++) begin
      win_bytes[i] = win_bytes[i+1];
    end
    win_bytes[WINDOW-1] = folded;
    if (win_fill < WINDOW) begin
      win_fill++;
    end
    for (int r = 0; r < RULES; r++) begin
      len = kw_text[r].len();
      if (len <= win_fill) begin
        same = 1'b1;
        for (int j = 0; j < len; j++) begin
          if (win_bytes[WINDOW-len+j] != kw_text[r][j]) begin
            same = 1'b0;
          end
        end
        if (same) begin
          hit_mask[r] = 1'b1;
        end
      end
    end
  endfunction

  // Apply one accepted item; a last item queues the message verdict.
  function automatic void absorb_item(logic [7:0] b, logic present, logic last);
    verdict_t    v;
    int unsigned sum;
    int unsigned top;
    if (present && !text_done) begin
      if (b == NUL_BYTE) begin
        text_done = 1'b1;
      end else begin
        shift_in_byte(b);
      end
    end
    if (last) begin
      sum        = 0;
      top        = 0;
      v.category = CAT_NONE;
      for (int r = 0; r < RULES; r++) begin
        if (hit_mask[r]) begin
          sum += kw_weight[r];
          // strict compare: earliest rule keeps a tie
          if (kw_weight[r] > top) begin
            top        = kw_weight[r];
            v.category = kw_cat[r];
          end
        end
      end
      v.score     = (sum > SCORE_CAP) ? SCORE_CAP : sum[SCORE_W-1:0];
      v.any_match = |hit_mask;
      pending_verdicts.push_back(v);
      clear_scan_state();
    end
  endfunction

  // One input transfer. Idle cycles carry junk payload with valid low.
  task automatic send_item(input logic [7:0] b, input logic present, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i     <= 1'b0;
      text_byte_i    <= 8'($urandom);
      byte_present_i <= 1'($urandom);
      last_byte_i    <= 1'($urandom);
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    text_byte_i    <= b;
    byte_present_i <= present;
    last_byte_i    <= last;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    if (present || last) begin
      scan_items++;
    end
    absorb_item(b, present, last);
  endtask

  // Drop valid and hold off until every queued verdict has come back or max_cycles have passed.
  task automatic hold_until_drained(input int max_cycles);
    int waited;
    waited     = 0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_verdicts.size() != 0 && waited < max_cycles) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  // Result side: check each output transfer, then pick the next stall.
  always @(posedge clk_i) begin : result_check
    verdict_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_verdicts.size() == 0) begin
        report_failure($sformatf("unexpected result score=%0d any=%0b cat=%0d",
                                 score_o, any_match_o, category_o));
      end else begin
        want = pending_verdicts.pop_front();
        if (score_o !== want.score || any_match_o !== want.any_match ||
            category_o !== want.category) begin
          report_failure($sformatf(
            "result %0d: expected score=%0d any=%0b cat=%0d, got score=%0d any=%0b cat=%0d",
            result_count, want.score, want.any_match, want.category,
            score_o, any_match_o, category_o));
        end
      end
      result_count++;
    end
    out_stall_i <= rst_ni && ($urandom_range(99) < recv_stall_pct);
  end

  // Empty message, an ignored item, and an end marker carrying a zero byte.
  task automatic test_empty_and_ignored();
    send_item(8'hFF, 1'b0, 1'b1);
    send_item("o", 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
  endtask

  // Mixed case keyword, last item carries the final byte.
  task automatic test_case_folding();
    send_item("O", 1'b1, 1'b0);
    send_item("t", 1'b1, 1'b0);
    send_item("P", 1'b1, 1'b1);
  endtask

  // A zero byte ends the text: the keyword after it must not count.
  task automatic test_zero_byte();
    send_item(NUL_BYTE, 1'b1, 1'b0);
    send_item("o", 1'b1, 1'b0);
    send_item("t", 1'b1, 1'b0);
    send_item("p", 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
  endtask

  // Bytes just outside A-Z and high bytes pass unfolded; no match.
  task automatic test_non_letters();
    send_item(8'h40, 1'b1, 1'b0);
    send_item(8'h5B, 1'b1, 1'b0);
    send_item(8'h60, 1'b1, 1'b0);
    send_item(8'h7B, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
  endtask

  // Message built from whole keywords, keyword fragments, filler and raw bytes.
  // Fragments at the ends test that state does not leak across messages.
  task automatic send_random_message();
    logic [7:0] text [$];
    int         segs;
    int         pick;
    int         idx;
    int         len;
    int         cut;
    bit         end_on_byte;
    logic [7:0] c;
    segs = $urandom_range(1, 4);
    if ($urandom_range(99) < 4) begin
      segs = 0;
    end
    repeat (segs) begin
      pick = $urandom_range(99);
      idx  = $urandom_range(RULES - 1);
      len  = kw_text[idx].len();
      if (pick < 50) begin
        for (int j = 0; j < len; j++) begin
          c = kw_text[idx][j];
          if (c >= "a" && c <= "z" && $urandom_range(3) == 0) begin
            c = c - CASE_OFFSET;
          end
          text.push_back(c);
        end
      end else if (pick < 65) begin
        cut = $urandom_range(1, len - 1);
        for (int j = 0; j < cut; j++) begin
          text.push_back(kw_text[idx][j]);
        end
      end else if (pick < 75) begin
        cut = $urandom_range(1, len - 1);
        for (int j = cut; j < len; j++) begin
          text.push_back(kw_text[idx][j]);
        end
      end else if (pick < 92) begin
        // lowercase letters and spaces
        repeat ($urandom_range(0, 8)) begin
          text.push_back(($urandom_range(3) == 0) ? 8'h20 : 8'($urandom_range(97, 122)));
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          text.push_back(8'($urandom_range(1, 255)));
        end
      end
    end
    if (text.size() > 0 && $urandom_range(99) < 6) begin
      text.insert($urandom_range(text.size() - 1), NUL_BYTE);
    end
    if ($urandom_range(99) < 3) begin
      text.push_back(NUL_BYTE);
    end
    end_on_byte = 1'($urandom);
    foreach (text[k]) begin
      if ($urandom_range(99) < 5) begin
        send_item(8'($urandom), 1'b0, 1'b0);
      end
      send_item(text[k], 1'b1, end_on_byte && (k == text.size() - 1));
    end
    if (!end_on_byte || text.size() == 0) begin
      send_item(8'($urandom), 1'b0, 1'b1);
    end
  endtask

  task automatic test_random_traffic(input int n_items, input int idle_pct,
                                     input int stall_pct);
    int start;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start          = scan_items;
    while (scan_items - start < n_items) begin
      send_random_message();
    end
  endtask

  initial begin
    clear_scan_state();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 6;
    recv_stall_pct = 53;
    test_empty_and_ignored();
    test_case_folding();
    test_zero_byte();
    test_non_letters();

    test_random_traffic(570, 6, 53);
    // sender holds off until the result pipe is empty
    hold_until_drained(20000);
    test_random_traffic(570, 53, 6);
    test_random_traffic(570, 0, 0);

    hold_until_drained(20000);
    // quiet tail to catch any stray result
    repeat (2 * RULES + 10) @(posedge clk_i);
    if (pending_verdicts.size() != 0) begin
      report_failure($sformatf("%0d results never arrived", pending_verdicts.size()));
    end

    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/wks_pkg.sv
hdl/wks_win_cell.sv
hdl/wks_sum_cell.sv
hdl/weighted_keyword_scanner.sv
tb/tb.sv
